// ----- hw/rtl/bblru_pkg.sv -----
// ----------------------------------------------------------------------------
// bblru_pkg: shared types and constants of the byte-budget LRU policy core
// Sizes, status codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package bblru_pkg;
	localparam int Entries = 16;
	localparam int RankW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CntW = $clog2(Entries + 1);
	localparam logic [31:0] BudgetReset = 32'd16777216;

	localparam logic [2:0] StHit = 3'd0;
	localparam logic [2:0] StInsert = 3'd1;
	localparam logic [2:0] StBypass = 3'd2;
	localparam logic [2:0] StDecFail = 3'd3;
	localparam logic [2:0] StClear = 3'd4;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic clear;        // drop the entry
		logic promote;      // hit: ranks below hit_rank age by one
		logic [RankW-1:0] hit_rank;
		logic evict;        // drop the entry whose rank is evict_rank
		logic [RankW-1:0] evict_rank;
		logic write;        // insert: valid entries age, the free grant winner is filled
		logic [31:0] key;
		logic [31:0] size;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bblru_cell.sv -----
// ----------------------------------------------------------------------------
// bblru_cell: one cache slot
// Holds key, size, valid and recency rank; passes the free grant onwards.
// ----------------------------------------------------------------------------
`default_nettype none
module bblru_cell (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bblru_pkg::cell_ctl_t    ctl,
	input  wire logic                    free_in,   // a lower slot is already free
	output logic                         free_out,
	output logic                         match,
	output logic [bblru_pkg::RankW-1:0]  rank,
	output logic                         oldest,
	output logic [31:0]                  size
);
	logic valid_q;
	logic [bblru_pkg::RankW-1:0] rank_q;
	logic [31:0] key_q;
	logic [31:0] size_q;
	logic take;

	assign take = ctl.write && !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign match = valid_q && (key_q == ctl.key);
	assign rank = rank_q;
	assign oldest = valid_q && (rank_q == ctl.evict_rank);
	assign size = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q <= '0;
		end else if (ctl.clear || (ctl.evict && oldest)) begin
			valid_q <= 1'b0;
			rank_q <= '0;
		end else if (ctl.promote && valid_q) begin
			if (match)
				rank_q <= '0;
			else if (rank_q < ctl.hit_rank)
				rank_q <= rank_q + 1'b1;
		end else if (ctl.write) begin
			if (valid_q)
				rank_q <= rank_q + 1'b1;
			else if (take) begin
				valid_q <= 1'b1;
				rank_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= ctl.key;
			size_q <= ctl.size;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/byte_budget_lru_cache_policy_core.sv -----
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_policy_core: LRU cache policy under a byte budget
// Row of slot cells and a small controller with running counters.
// ----------------------------------------------------------------------------
// Usage. Items enter on in_valid/in_ready with action, frame_id,
// payload_size and decode_ok, and each produces one result item on
// out_valid/out_ready. The user must write the byte_budget register with
// cfg_we and cfg_wdata only while the block is idle; the block itself does
// not enforce this. Timing: an item is taken in S_IDLE; the tag match over
// all slots and the decision happen in S_DECIDE, which waits while the
// output register is still full. Each eviction of a least recent entry
// then takes its own step in S_EVICT, followed by the insert. The eviction
// loop through the slot row sets the rate.
// One item is worked on at a time. The result is held in an output
// register; when the receiver stalls, the result waits there and the next
// item may already be accepted, but it is not finished until the register
// is free again.
// Reset clears the table, the counters and the budget (to 16 MiB) at once;
// the key and size stores are not cleared and are read only where valid.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_budget_lru_cache_policy_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [31:0] frame_id,
	input  wire logic [31:0] payload_size,
	input  wire logic        decode_ok,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [4:0]       evicted_now,
	output logic [31:0]      resident_bytes,
	output logic [4:0]       entry_count,
	output logic [31:0]      hits_total,
	output logic [31:0]      misses_total,
	output logic [31:0]      evictions_total,
	output logic [31:0]      bypasses_total
);
	localparam int N = bblru_pkg::Entries;
	localparam int RW = bblru_pkg::RankW;
	localparam int CW = bblru_pkg::CntW;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_EVICT  = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] budget_q;
	logic action_q, ok_q;
	logic [31:0] key_q, bytes_q;
	logic [31:0] resident_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] evicted_q;
	logic [31:0] hit_cnt_q, miss_cnt_q, evict_cnt_q, byp_cnt_q;

	bblru_pkg::cell_ctl_t ctl;
	logic [N:0] free_chain;
	logic [N-1:0] match_v, oldest_v;
	logic [RW-1:0] rank_v [N];
	logic [31:0] size_v [N];

	genvar g;
	assign free_chain[0] = 1'b0;
	for (g = 0; g < N; g++) begin : g_cell
		bblru_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.free_in(free_chain[g]), .free_out(free_chain[g+1]),
			.match(match_v[g]), .rank(rank_v[g]), .oldest(oldest_v[g]),
			.size(size_v[g])
		);
	end

	// Match rank and oldest size: one-hot selects across the row.
	logic hit;
	logic [RW-1:0] hit_rank;
	logic [31:0] old_size;
	always_comb begin
		hit_rank = '0;
		old_size = '0;
		for (int i = 0; i < N; i++) begin
			if (match_v[i])
				hit_rank = hit_rank | rank_v[i];
			if (oldest_v[i])
				old_size = old_size | size_v[i];
		end
	end
	assign hit = |match_v;

	logic [32:0] need;
	logic must_evict;
	assign need = {1'b0, resident_q} + {1'b0, bytes_q};
	assign must_evict = (count_q != '0) &&
		((need > {1'b0, budget_q}) || (count_q >= CW'(N)));

	logic [RW-1:0] lru_rank;
	assign lru_rank = RW'(count_q - 1'b1);

	// The decision waits while an earlier result still sits in the output register.
	logic out_free;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		ctl = '0;
		ctl.key = key_q;
		ctl.size = bytes_q;
		ctl.hit_rank = hit_rank;
		ctl.evict_rank = lru_rank;
		if (state_q == S_DECIDE) begin
			if (out_free) begin
				if (action_q)
					ctl.clear = 1'b1;
				else if (hit)
					ctl.promote = 1'b1;
			end
		end else if (state_q == S_EVICT) begin
			if (must_evict)
				ctl.evict = 1'b1;
			else
				ctl.write = 1'b1;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			budget_q <= bblru_pkg::BudgetReset;
		else if (cfg_we)
			budget_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_q <= action;
			key_q <= frame_id;
			bytes_q <= payload_size;
			ok_q <= decode_ok;
		end
	end

	logic [31:0] res_s;
	logic [CW-1:0] cnt_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resident_q <= '0;
			count_q <= '0;
			evicted_q <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			evict_cnt_q <= '0;
			byp_cnt_q <= '0;
			out_valid <= 1'b0;
			status <= bblru_pkg::StHit;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECIDE;
					evicted_q <= '0;
				end
				S_DECIDE: begin
					if (out_free) begin
						if (action_q) begin
							resident_q <= '0;
							count_q <= '0;
							status <= bblru_pkg::StClear;
							state_q <= S_DONE;
						end else if (hit) begin
							hit_cnt_q <= hit_cnt_q + 1'b1;
							status <= bblru_pkg::StHit;
							state_q <= S_DONE;
						end else begin
							miss_cnt_q <= miss_cnt_q + 1'b1;
							if (!ok_q) begin
								status <= bblru_pkg::StDecFail;
								state_q <= S_DONE;
							end else if (bytes_q > budget_q) begin
								byp_cnt_q <= byp_cnt_q + 1'b1;
								status <= bblru_pkg::StBypass;
								state_q <= S_DONE;
							end else begin
								status <= bblru_pkg::StInsert;
								state_q <= S_EVICT;
							end
						end
					end
				end
				S_EVICT: begin
					if (must_evict) begin
						resident_q <= resident_q - old_size;
						count_q <= count_q - 1'b1;
						evicted_q <= evicted_q + 1'b1;
						evict_cnt_q <= evict_cnt_q + 1'b1;
					end else begin
						resident_q <= need[31:0];
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_s = resident_q;
	assign cnt_s = count_q;

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			evicted_now <= (CW > 5 && evicted_q > CW'(31)) ? 5'd31 : 5'(evicted_q);
			resident_bytes <= res_s;
			entry_count <= (CW > 5 && cnt_s > CW'(31)) ? 5'd31 : 5'(cnt_s);
			hits_total <= hit_cnt_q;
			misses_total <= miss_cnt_q;
			evictions_total <= evict_cnt_q;
			bypasses_total <= byp_cnt_q;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/bblru_checker.sv -----
// ----------------------------------------------------------------------------
// bblru_checker: port-level checks of the policy core
// Watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bblru_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [4:0]  evicted_now,
	input wire logic [4:0]  entry_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= bblru_pkg::StClear)
		else $error("bad status");
	a_evict_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_now != 5'd0 |-> status == bblru_pkg::StInsert)
		else $error("eviction without insert");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bblru_pkg::StClear |->
			entry_count == 5'd0 && evicted_now == 5'd0)
		else $error("clear left entries");
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken too soon");
endmodule

bind byte_budget_lru_cache_policy_core bblru_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.evicted_now(evicted_now), .entry_count(entry_count)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the byte-budget LRU cache policy core
// A directed opening and a long random run of reads and clears on a small key
// set, predicted by a cache table held in the testbench and checked per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int WatchLimit = 20000;

	// One expected result item; the fields mirror the output ports.
	typedef struct packed {
		logic [2:0] status;
		logic [4:0] evicted_now;
		logic [31:0] resident_bytes;
		logic [4:0] entry_count;
		logic [31:0] hits_total;
		logic [31:0] misses_total;
		logic [31:0] evictions_total;
		logic [31:0] bypasses_total;
	} cache_result_t;

	// The scoreboard keeps its own copy of the cache table and the counters.
	// Each accepted item updates that copy, and the result that it should give
	// is queued until the block delivers its own.
	class lru_scoreboard;
		logic [31:0] budget;
		logic [31:0] slot_key[bblru_pkg::Entries];
		logic [31:0] slot_size[bblru_pkg::Entries];
		bit slot_live[bblru_pkg::Entries];
		int unsigned slot_age[bblru_pkg::Entries];
		logic [31:0] held_bytes;
		int unsigned live_count;
		logic [31:0] n_hit, n_miss, n_evict, n_bypass;
		cache_result_t pending[$];
		int errors;

		function void restart();
			budget = bblru_pkg::BudgetReset;
			for (int i = 0; i < bblru_pkg::Entries; i++) begin
				slot_live[i] = 0;
				slot_age[i] = 0;
			end
			held_bytes = 0;
			live_count = 0;
			n_hit = 0;
			n_miss = 0;
			n_evict = 0;
			n_bypass = 0;
			pending.delete();
			errors = 0;
		endfunction

		// Drop the least recent entry; ranks of the others stay as they are.
		function void drop_oldest();
			for (int i = 0; i < bblru_pkg::Entries; i++) begin
				if (slot_live[i] && slot_age[i] + 1 == live_count) begin
					slot_live[i] = 0;
					slot_age[i] = 0;
					held_bytes = held_bytes - slot_size[i];
					live_count--;
					n_evict++;
					return;
				end
			end
		endfunction

		function void note_item(logic clr, logic [31:0] key, logic [31:0] nbytes, logic ok);
			cache_result_t r;
			int found;
			int unsigned dropped;
			int unsigned hr;
			found = -1;
			dropped = 0;
			if (clr) begin
				for (int i = 0; i < bblru_pkg::Entries; i++) begin
					slot_live[i] = 0;
					slot_age[i] = 0;
				end
				held_bytes = 0;
				live_count = 0;
				r.status = bblru_pkg::StClear;
			end else begin
				for (int i = 0; i < bblru_pkg::Entries; i++) begin
					if (found < 0 && slot_live[i] && slot_key[i] == key)
						found = i;
				end
				if (found >= 0) begin
					hr = slot_age[found];
					n_hit++;
					for (int i = 0; i < bblru_pkg::Entries; i++)
						if (slot_live[i] && slot_age[i] < hr)
							slot_age[i]++;
					slot_age[found] = 0;
					r.status = bblru_pkg::StHit;
				end else begin
					n_miss++;
					if (!ok) begin
						r.status = bblru_pkg::StDecFail;
					end else if (nbytes > budget) begin
						n_bypass++;
						r.status = bblru_pkg::StBypass;
					end else begin
						// The sum is taken at 33 bits so that it cannot wrap.
						while (live_count > 0 && ({1'b0, held_bytes} + {1'b0, nbytes} >
								{1'b0, budget} || live_count >= bblru_pkg::Entries)) begin
							drop_oldest();
							dropped++;
						end
						for (int i = 0; i < bblru_pkg::Entries; i++)
							if (slot_live[i])
								slot_age[i]++;
						for (int i = 0; i < bblru_pkg::Entries; i++) begin
							if (!slot_live[i]) begin
								slot_live[i] = 1;
								slot_key[i] = key;
								slot_size[i] = nbytes;
								slot_age[i] = 0;
								break;
							end
						end
						held_bytes = held_bytes + nbytes;
						live_count++;
						r.status = bblru_pkg::StInsert;
					end
				end
			end
			r.evicted_now = (dropped > 31) ? 5'd31 : 5'(dropped);
			r.resident_bytes = held_bytes;
			r.entry_count = (live_count > 31) ? 5'd31 : 5'(live_count);
			r.hits_total = n_hit;
			r.misses_total = n_miss;
			r.evictions_total = n_evict;
			r.bypasses_total = n_bypass;
			pending.push_back(r);
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: status %0d", got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.evicted_now !== want.evicted_now) begin
				$error("evicted_now: expected %0d, got %0d", want.evicted_now, got.evicted_now);
				errors++;
			end
			if (got.resident_bytes !== want.resident_bytes) begin
				$error("resident_bytes: expected %0d, got %0d", want.resident_bytes,
					got.resident_bytes);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
				errors++;
			end
			if (got.hits_total !== want.hits_total) begin
				$error("hits_total: expected %0d, got %0d", want.hits_total, got.hits_total);
				errors++;
			end
			if (got.misses_total !== want.misses_total) begin
				$error("misses_total: expected %0d, got %0d", want.misses_total, got.misses_total);
				errors++;
			end
			if (got.evictions_total !== want.evictions_total) begin
				$error("evictions_total: expected %0d, got %0d", want.evictions_total,
					got.evictions_total);
				errors++;
			end
			if (got.bypasses_total !== want.bypasses_total) begin
				$error("bypasses_total: expected %0d, got %0d", want.bypasses_total,
					got.bypasses_total);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic action = 0;
	logic [31:0] frame_id = '0;
	logic [31:0] payload_size = '0;
	logic decode_ok = 0;
	logic out_valid;
	logic out_ready = 0;
	cache_result_t got;

	lru_scoreboard board;
	int idle_cycles = 0;
	bit stimulus_done = 0;
	int unsigned burst_left = 0;

	always #2 clk = ~clk;

	byte_budget_lru_cache_policy_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.frame_id(frame_id),
		.payload_size(payload_size),
		.decode_ok(decode_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(got.status),
		.evicted_now(got.evicted_now),
		.resident_bytes(got.resident_bytes),
		.entry_count(got.entry_count),
		.hits_total(got.hits_total),
		.misses_total(got.misses_total),
		.evictions_total(got.evictions_total),
		.bypasses_total(got.bypasses_total)
	);

	// Inputs are sampled at the edge, before the nonblocking updates land, so the
	// handshakes seen here are exactly those that the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_item(action, frame_id, payload_size, decode_ok);
			if (out_valid && out_ready)
				board.check_result(got);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// The receiver stalls at random; out_ready is high at 61 percent of draws,
	// so that results back up into the core; after the stimulus it stays high.
	always @(posedge clk) begin
		int unsigned mode;
		mode = $urandom_range(0, 99);
		if (stimulus_done)
			out_ready <= 1'b1;
		else if (mode < 60)
			out_ready <= 1'b1;
		else if (mode < 95)
			out_ready <= 1'b0;
		else
			out_ready <= (mode == 99) ? 1'b1 : 1'b0;
	end

	// A gap between bursts; during a burst valid goes up again on the same edge
	// that takes the previous item, so it is never lowered and raised in one step.
	task automatic send_item(logic clr, logic [31:0] key, logic [31:0] nbytes, logic ok);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= clr;
		frame_id <= key;
		payload_size <= nbytes;
		decode_ok <= ok;
		do @(posedge clk); while (!in_ready);
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	// Lower valid, let every expected result arrive and give the core time to
	// settle before the register changes.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_budget(logic [31:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.budget = value;
	endtask

	// Keys come mostly from a small pool so that hits and evictions are common;
	// sizes are scaled to the budget in force so that inserts, evictions and
	// bypasses all occur.
	task automatic random_items(int count, logic [31:0] bud);
		logic [31:0] key, nbytes;
		int unsigned pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			key = (pick < 85) ? 32'($urandom_range(0, 23)) : $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				nbytes = (bud < 8) ? 32'($urandom_range(0, bud)) : ($urandom % (bud / 4 + 1));
			else if (pick < 90)
				nbytes = 32'($urandom % ({1'b0, bud} + 33'd1));
			else
				nbytes = $urandom;
			send_item($urandom_range(0, 49) == 0, key, nbytes, $urandom_range(0, 9) != 0);
		end
	endtask

	initial begin
		board = new();
		board.restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset budget: field extremes, every status.
		send_item(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1);
		send_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1);
		send_item(1'b0, 32'd1, 32'd100, 1'b0);
		send_item(1'b0, 32'd2, bblru_pkg::BudgetReset, 1'b1);
		send_item(1'b0, 32'd3, 32'd1, 1'b1);
		send_item(1'b0, 32'd2, 32'd0, 1'b0);
		for (int i = 0; i < 17; i++)
			send_item(1'b0, 32'h100 + 32'(i), 32'd0, 1'b1);
		send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		// The sender waits here until the core has delivered every result.
		drain();
		random_items(150, bblru_pkg::BudgetReset);

		set_budget(32'd1);
		random_items(80, 32'd1);
		set_budget(32'd100);
		random_items(200, 32'd100);
		// A lowered budget with older entries kept can force a chain of evictions.
		set_budget(32'd20);
		random_items(120, 32'd20);
		set_budget(32'hFFFF_FFFF);
		send_item(1'b0, 32'h55, 32'hFFFF_FFFF, 1'b1);
		send_item(1'b0, 32'h56, 32'hFFFF_FFFF, 1'b1);
		random_items(150, 32'hFFFF_FFFF);

		drain();
		stimulus_done = 1;
		repeat (30) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchLimit) begin
			$display("simulation failed");
			$finish;
		end
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/bblru_pkg.sv
hw/rtl/bblru_cell.sv
hw/rtl/byte_budget_lru_cache_policy_core.sv
hw/rtl/bblru_checker.sv
verif/tb_top.sv
